>>> rtl/rpm_pkg.sv
// Package for the relator pair move engine: item types, command and status
// codes, lane control types and letter-level helper functions. No dependencies.
`timescale 1ns / 1ps

package rpm_pkg;

    localparam int SLOTS           = 32;
    localparam int WORD_W          = 64;
    localparam int LEN_W           = 6;
    localparam int MAX_LETTERS_DEF = 32;

    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_COMPOSE = 3'd1;
    localparam logic [2:0] CMD_INVERT  = 3'd2;
    localparam logic [2:0] CMD_CONJ    = 3'd3;
    localparam logic [2:0] CMD_ROTATE  = 3'd4;
    localparam logic [2:0] CMD_CANON   = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_TOOLONG = 2'd1;
    localparam logic [1:0] ST_ROTFAR  = 2'd2;

    typedef struct packed {
        logic [2:0]        cmd;
        logic              target;
        logic              other_word;
        logic [1:0]        generator;
        logic [5:0]        rotate_first;
        logic [5:0]        rotate_second;
        logic [WORD_W-1:0] load_word;
        logic [LEN_W-1:0]  load_length;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [LEN_W-1:0]  first_length;
        logic [WORD_W-1:0] second_word;
        logic [LEN_W-1:0]  second_length;
        logic [1:0]        status;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic canon;
    } lane_ctl_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } lane_res_t;

    // ones over the first n letters
    function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] m;
        if (n >= LEN_W'(SLOTS)) begin
            m = '1;
        end else begin
            m = (WORD_W'(1) << {n, 1'b0}) - WORD_W'(1);
        end
        return m;
    endfunction

    // letter order reversed, so letter 0 lands in the top bits
    function automatic logic [WORD_W-1:0] rev_letters(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < SLOTS; i++) begin
            r[2*i +: 2] = w[2*(SLOTS-1-i) +: 2];
        end
        return r;
    endfunction

    // move amt letters of an n-letter word from front to back (amt <= n)
    function automatic logic [WORD_W-1:0] rotate_word(input logic [WORD_W-1:0] w,
                                                     input logic [LEN_W-1:0]  n,
                                                     input logic [LEN_W-1:0]  amt);
        logic [LEN_W-1:0] rest;
        rest = n - amt;
        return ((w >> {amt, 1'b0}) | (w << {rest, 1'b0})) & len_mask(n);
    endfunction

    function automatic logic [1:0] pick_letter(input logic [WORD_W-1:0] w,
                                               input logic [4:0]        idx);
        return w[{idx, 1'b0} +: 2];
    endfunction

endpackage

>>> rtl/rpm_lane.sv
// One lane: trims inverse end letters, then optionally searches for the
// greatest rotation one candidate per cycle. Depends on rpm_pkg.
`timescale 1ns / 1ps

module rpm_lane import rpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  lane_ctl_t         ctl,
    input  logic [WORD_W-1:0] word_in,
    input  logic [LEN_W-1:0]  len_in,
    output lane_res_t         res
);

    logic              busy_reg, busy_next;
    logic              search_reg, search_next;
    logic              canon_reg, canon_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [WORD_W-1:0] best_reg, best_next;
    logic [LEN_W-1:0]  c_reg, c_next;

    logic [1:0]        tail;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] best_sel;

    always_comb begin
        busy_next   = busy_reg;
        search_next = search_reg;
        canon_next  = canon_reg;
        done_next   = done_reg;
        w_next      = w_reg;
        n_next      = n_reg;
        best_next   = best_reg;
        c_next      = c_reg;
        tail        = pick_letter(w_reg, 5'(n_reg - LEN_W'(1)));
        cand        = rotate_word(w_reg, n_reg, c_reg);
        best_sel    = (rev_letters(cand) > rev_letters(best_reg)) ? cand : best_reg;

        if (ctl.start) begin
            busy_next   = 1'b1;
            search_next = 1'b0;
            canon_next  = ctl.canon;
            done_next   = 1'b0;
            w_next      = word_in;
            n_next      = len_in;
        end else if (busy_reg) begin
            if (!search_reg) begin
                if (n_reg > LEN_W'(1) && w_reg[1:0] == ~tail) begin
                    // drop a letter from each end
                    w_next = (w_reg >> 2) & len_mask(n_reg - LEN_W'(2));
                    n_next = n_reg - LEN_W'(2);
                end else if (canon_reg && n_reg > LEN_W'(1)) begin
                    search_next = 1'b1;
                    best_next   = w_reg;
                    c_next      = LEN_W'(1);
                end else begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else begin
                // strict greater keeps the earliest rotation on ties
                best_next = best_sel;
                if (c_reg == n_reg - LEN_W'(1)) begin
                    w_next    = best_sel;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    c_next = c_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            search_reg <= 1'b0;
            canon_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            search_reg <= search_next;
            canon_reg  <= canon_next;
            done_reg   <= done_next;
        end
        w_reg    <= w_next;
        n_reg    <= n_next;
        best_reg <= best_next;
        c_reg    <= c_next;
    end

    assign res.done = done_reg;
    assign res.word = w_reg;
    assign res.len  = n_reg;

endmodule

>>> rtl/rpm_reduce.sv
// Free reduction of g.w.g^-1 through a letter stack, one letter per cycle.
// Depends on rpm_pkg.
`timescale 1ns / 1ps

module rpm_reduce import rpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] word_in,
    input  logic [LEN_W-1:0]  len_in,
    input  logic [1:0]        gen_in,
    output lane_res_t         res
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [1:0]        g_reg, g_next;
    logic [LEN_W-1:0]  i_reg, i_next;
    logic [WORD_W-1:0] stk_reg, stk_next;
    logic [LEN_W-1:0]  sp_reg, sp_next;

    logic [1:0]        x;
    logic [1:0]        top;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        w_next    = w_reg;
        n_next    = n_reg;
        g_next    = g_reg;
        i_next    = i_reg;
        stk_next  = stk_reg;
        sp_next   = sp_reg;
        top       = pick_letter(stk_reg, 5'(sp_reg - LEN_W'(1)));
        if (i_reg == LEN_W'(0)) begin
            x = g_reg;
        end else if (i_reg == n_reg + LEN_W'(1)) begin
            x = ~g_reg;
        end else begin
            x = pick_letter(w_reg, 5'(i_reg - LEN_W'(1)));
        end

        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            w_next    = word_in;
            n_next    = len_in;
            g_next    = gen_in;
            i_next    = '0;
            stk_next  = '0;
            sp_next   = '0;
        end else if (busy_reg) begin
            if (sp_reg != LEN_W'(0) && top == ~x) begin
                // cancel against the stack top
                stk_next[{5'(sp_reg - LEN_W'(1)), 1'b0} +: 2] = 2'b00;
                sp_next = sp_reg - LEN_W'(1);
            end else if (sp_reg < LEN_W'(SLOTS)) begin
                stk_next[{sp_reg[4:0], 1'b0} +: 2] = x;
                sp_next = sp_reg + LEN_W'(1);
            end
            if (i_reg == n_reg + LEN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                i_next = i_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        w_reg   <= w_next;
        n_reg   <= n_next;
        g_reg   <= g_next;
        i_reg   <= i_next;
        stk_reg <= stk_next;
        sp_reg  <= sp_next;
    end

    assign res.done = done_reg;
    assign res.word = stk_reg;
    assign res.len  = sp_reg;

endmodule

>>> rtl/rpm_merge.sv
// Merge stage for canonicalize: orders the two lane results, greater word
// first, a proper prefix counting as lesser. Depends on rpm_pkg.
`timescale 1ns / 1ps

module rpm_merge import rpm_pkg::*; (
    input  lane_res_t lane_a,
    input  lane_res_t lane_b,
    output lane_res_t first,
    output lane_res_t second
);

    logic [WORD_W-1:0] ra;
    logic [WORD_W-1:0] rb;
    logic              less;

    always_comb begin
        ra   = rev_letters(lane_a.word);
        rb   = rev_letters(lane_b.word);
        // zero padding never beats a longer word, so length breaks only ties
        less = (ra < rb) || (ra == rb && lane_a.len < lane_b.len);
        if (less) begin
            first  = lane_b;
            second = lane_a;
        end else begin
            first  = lane_a;
            second = lane_b;
        end
    end

endmodule

>>> rtl/relator_pair_move_engine_top.sv
// Top level of the relator pair move engine: command sequencer, word store,
// two canonicalizing lanes, stack reducer, merge and output register. Uses rpm_pkg.
`timescale 1ns / 1ps

// Channel  | Ports                      | Item
// input    | s_valid s_ready s_data     | in_item_t: command and operands
// result   | m_valid m_ready m_data     | out_item_t: both words and status
//
// One item at a time. Load, invert, rotate, unused and refused moves go straight from the
// execute state to the output state. Compose cancels inverse letter pairs at the join, then
// trims end pairs in lane 0. Conjugate runs through the stack reducer. Canonicalize ends
// when the slower lane is done. Reset clears both words to empty. A stalled result holds
// the next result in the sequencer; a new item is accepted while a result still waits.

module relator_pair_move_engine_top import rpm_pkg::*; #(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LETTERS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_JOIN   = 3'd2;
    localparam logic [2:0] S_TRIM   = 3'd3;
    localparam logic [2:0] S_REDUCE = 3'd4;
    localparam logic [2:0] S_CANON  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [1:0]        status_reg, status_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [WORD_W-1:0] word_reg [2];
    logic [WORD_W-1:0] word_next [2];
    logic [LEN_W-1:0]  len_reg [2];
    logic [LEN_W-1:0]  len_next [2];
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    lane_ctl_t         ctl0, ctl1;
    logic [WORD_W-1:0] lane0_word;
    logic [LEN_W-1:0]  lane0_len;
    lane_res_t         res0, res1, red_res, first, second;
    logic              red_start;

    logic [WORD_W-1:0] wa, wb;
    logic [LEN_W-1:0]  la, lb, lj, ll;
    logic [LEN_W:0]    lsum;
    logic              join_hit;

    rpm_lane u_lane0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl0),
        .word_in (lane0_word),
        .len_in  (lane0_len),
        .res     (res0)
    );

    rpm_lane u_lane1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl1),
        .word_in (word_reg[1]),
        .len_in  (len_reg[1]),
        .res     (res1)
    );

    rpm_reduce u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .word_in (wa),
        .len_in  (la),
        .gen_in  (item_reg.generator),
        .res     (red_res)
    );

    rpm_merge u_merge (
        .lane_a (res0),
        .lane_b (res1),
        .first  (first),
        .second (second)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        status_next  = status_reg;
        j_next       = j_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ctl0         = '0;
        ctl1         = '0;
        red_start    = 1'b0;

        wa       = word_reg[item_reg.target];
        la       = len_reg[item_reg.target];
        wb       = word_reg[item_reg.other_word];
        lb       = len_reg[item_reg.other_word];
        lsum     = {1'b0, la} + {1'b0, lb};
        lj       = la - j_reg;
        join_hit = (j_reg < la) && (j_reg < lb) &&
                   (pick_letter(wa, 5'(lj - LEN_W'(1))) == ~pick_letter(wb, j_reg[4:0]));
        ll       = (item_reg.load_length > MAX_LEN) ? MAX_LEN : item_reg.load_length;

        // lane 0 takes the joined word on compose, the first word on canonicalize
        if (state_reg == S_JOIN) begin
            lane0_word = (wa & len_mask(lj)) | ((wb >> {j_reg, 1'b0}) << {lj, 1'b0});
            lane0_len  = LEN_W'(lsum - {j_reg, 1'b0});
        end else begin
            lane0_word = word_reg[0];
            lane0_len  = len_reg[0];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    status_next = ST_DONE;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
                unique case (item_reg.cmd)
                    CMD_LOAD: begin
                        word_next[item_reg.target] = item_reg.load_word & len_mask(ll);
                        len_next[item_reg.target]  = ll;
                    end
                    CMD_COMPOSE: begin
                        if (lsum > {1'b0, MAX_LEN}) begin
                            status_next = ST_TOOLONG;
                        end else begin
                            j_next     = '0;
                            state_next = S_JOIN;
                        end
                    end
                    CMD_INVERT: begin
                        word_next[item_reg.target] =
                            (~rev_letters(wa) >> {6'(LEN_W'(SLOTS) - la), 1'b0}) & len_mask(la);
                    end
                    CMD_CONJ: begin
                        if ({1'b0, la} + (LEN_W+1)'(2) > {1'b0, MAX_LEN}) begin
                            status_next = ST_TOOLONG;
                        end else begin
                            red_start  = 1'b1;
                            state_next = S_REDUCE;
                        end
                    end
                    CMD_ROTATE: begin
                        if (item_reg.rotate_first > len_reg[0] ||
                            item_reg.rotate_second > len_reg[1]) begin
                            status_next = ST_ROTFAR;
                        end else begin
                            word_next[0] = rotate_word(word_reg[0], len_reg[0],
                                                       item_reg.rotate_first);
                            word_next[1] = rotate_word(word_reg[1], len_reg[1],
                                                       item_reg.rotate_second);
                        end
                    end
                    CMD_CANON: begin
                        ctl0       = '{start: 1'b1, canon: 1'b1};
                        ctl1       = '{start: 1'b1, canon: 1'b1};
                        state_next = S_CANON;
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_JOIN: begin
                if (join_hit) begin
                    j_next = j_reg + LEN_W'(1);
                end else begin
                    ctl0       = '{start: 1'b1, canon: 1'b0};
                    state_next = S_TRIM;
                end
            end
            S_TRIM: begin
                if (res0.done) begin
                    word_next[item_reg.target] = res0.word;
                    len_next[item_reg.target]  = res0.len;
                    state_next                 = S_OUT;
                end
            end
            S_REDUCE: begin
                if (red_res.done) begin
                    word_next[item_reg.target] = red_res.word;
                    len_next[item_reg.target]  = red_res.len;
                    state_next                 = S_OUT;
                end
            end
            S_CANON: begin
                if (res0.done && res1.done) begin
                    word_next[0] = first.word;
                    len_next[0]  = first.len;
                    word_next[1] = second.word;
                    len_next[1]  = second.len;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{first_word:    word_reg[0],
                                     first_length:  len_reg[0],
                                     second_word:   word_reg[1],
                                     second_length: len_reg[1],
                                     status:        status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            word_reg[0] <= '0;
            word_reg[1] <= '0;
            len_reg[0]  <= '0;
            len_reg[1]  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            word_reg    <= word_next;
            len_reg     <= len_next;
        end
        item_reg   <= item_next;
        status_reg <= status_next;
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
    end

endmodule
